// ----- rtl/core/ray_box_slab_intersect_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Ray box slab intersect unit: assertion macros
// Shared property macros; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_INTERSECT_UNIT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RBSI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbsi: same-cycle check failed");
// Next-cycle implication.
`define RBSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbsi: next-cycle check failed");
`else
`define RBSI_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RBSI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/rbsi_pkg.sv -----
// ----------------------------------------------------------------------------
// Ray box slab intersect package
// Types, constants and small helpers shared by the intersect pipeline.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int FX_W       = 32;
   localparam int FRAC_W     = 16;
   localparam int DIVIDEND_W = FX_W + FRAC_W;
   localparam int DIVISOR_W  = FX_W;
   localparam int DIV_STAGES = DIVIDEND_W;
   localparam int DIV_LAT    = DIV_STAGES + 1;
   localparam int PIPE_LAT   = DIV_LAT + 7;

   localparam logic signed [31:0] FX_ONE  = 32'sd65536;
   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   localparam logic [1:0] NORM_POS  = 2'b01;
   localparam logic [1:0] NORM_NEG  = 2'b11;
   localparam logic [1:0] NORM_ZERO = 2'b00;

   // One input item as captured at the front of the pipeline.
   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic signed [31:0] box_centre_x;
      logic signed [31:0] box_centre_y;
   } item_type;

   // Side data that travels alongside the slab time dividers.
   typedef struct packed {
      logic               axis_ok;
      logic               move_nz_x;
      logic               move_nz_y;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic signed [32:0] span_x;
      logic signed [32:0] span_y;
      logic signed [31:0] centre_x;
      logic signed [31:0] centre_y;
   } side_type;

   // Magnitude of a 33-bit two's complement value that is never -2^32.
   function automatic logic [31:0] mag33(input logic [32:0] v);
      logic [32:0] n;
      n = v[32] ? (~v + 33'd1) : v;
      return n[31:0];
   endfunction

   // Saturate a 49-bit signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
      logic signed [31:0] r;
      if (v > 49'sd2147483647) begin
         r = S32_MAX;
      end else if (v < -49'sd2147483648) begin
         r = S32_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/rbsi_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined slab time divider
// Restoring division, one quotient bit per stage, with signed saturation.
// ----------------------------------------------------------------------------
module rbsi_div (
   input  logic                                 clock,
   input  logic [rbsi_pkg::DIVIDEND_W-1:0]      dividend,
   input  logic [rbsi_pkg::DIVISOR_W-1:0]       divisor,
   input  logic                                 negate,
   output logic signed [rbsi_pkg::FX_W-1:0]     quotient
);

   localparam int N = rbsi_pkg::DIV_STAGES;
   localparam int W = rbsi_pkg::DIVIDEND_W;
   localparam int D = rbsi_pkg::DIVISOR_W;

   logic [D-1:0] rem_ff [N-1];
   logic [D-1:0] dvs_ff [N-1];
   logic [W-1:0] shq_ff [N];
   logic         neg_ff [N];
   logic signed [rbsi_pkg::FX_W-1:0] quot_ff;
   logic signed [rbsi_pkg::FX_W-1:0] quot_in;

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic [D-1:0] rem_prev;
      logic [D-1:0] dvs_prev;
      logic [W-1:0] shq_prev;
      logic         neg_prev;
      logic [D:0]   trial;
      logic         ge;
      logic [D-1:0] rem_in;
      logic [W-1:0] shq_in;

      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign dvs_prev = divisor;
         assign shq_prev = dividend;
         assign neg_prev = negate;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign dvs_prev = dvs_ff[i-1];
         assign shq_prev = shq_ff[i-1];
         assign neg_prev = neg_ff[i-1];
      end

      // Shift in the next dividend bit and subtract where the divisor fits.
      always_comb begin
         trial  = {rem_prev, shq_prev[W-1]};
         ge     = (trial >= {1'b0, dvs_prev});
         rem_in = ge ? D'(trial - {1'b0, dvs_prev}) : trial[D-1:0];
         shq_in = {shq_prev[W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         shq_ff[i] <= shq_in;
         neg_ff[i] <= neg_prev;
      end

      if (i < N - 1) begin : g_keep
         always_ff @(posedge clock) begin
            rem_ff[i] <= rem_in;
            dvs_ff[i] <= dvs_prev;
         end
      end
   end

   // Apply the sign and clamp the quotient to 32 bits.
   always_comb begin
      if (neg_ff[N-1]) begin
         if (shq_ff[N-1] > W'(64'h8000_0000)) begin
            quot_in = rbsi_pkg::S32_MIN;
         end else begin
            quot_in = -$signed(shq_ff[N-1][31:0]);
         end
      end else begin
         if (shq_ff[N-1] > W'(64'h7fff_ffff)) begin
            quot_in = rbsi_pkg::S32_MAX;
         end else begin
            quot_in = $signed(shq_ff[N-1][31:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quotient = quot_ff;

endmodule

// ----- rtl/core/ray_box_slab_intersect_unit.sv -----
// ----------------------------------------------------------------------------
// Ray box slab intersect unit
// 2D segment against axis-aligned box, slab test in signed Q16.16.
// ----------------------------------------------------------------------------
// The unit can take one item in every clock cycle and never raises busy once
// out of reset; each item gives exactly one result, strobed on rsp_valid in
// the order the items came in. Most of the pipeline depth lies in the slab
// time dividers, which produce one quotient bit per stage over 48 stages.
// Results are not held: the receiver must take each one in the cycle it
// is shown.
`include "ray_box_slab_intersect_unit_macros.svh"

module ray_box_slab_intersect_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_move_x,
   input  logic signed [31:0] req_move_y,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   input  logic signed [31:0] req_box_centre_x,
   input  logic signed [31:0] req_box_centre_y,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_entry_time,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [1:0]  rsp_normal_x,
   output logic signed [1:0]  rsp_normal_y
);

   localparam int LAT = rbsi_pkg::PIPE_LAT;
   localparam int DL  = rbsi_pkg::DIV_LAT;

   logic                 vld_ff [LAT];
   logic                 vld_in;
   rbsi_pkg::item_type   in_ff;
   rbsi_pkg::side_type   side_r1_in, side_r1_ff;
   rbsi_pkg::side_type   side_dl_ff [DL];
   rbsi_pkg::side_type   side_b_ff, side_c_ff, side_d_ff;

   logic [47:0] dvd_in [4];
   logic [47:0] dvd_ff [4];
   logic        neg_in [4];
   logic        neg_ff [4];
   logic [31:0] dvs_x_in, dvs_y_in, dvs_x_ff, dvs_y_ff;
   logic signed [31:0] quot [4];

   logic signed [31:0] entry_b_in, entry_b_ff, entry_c_ff, entry_d_ff, entry_e_ff;
   logic               hit_b_in, hit_b_ff, hit_c_ff, hit_d_ff, hit_e_ff;
   logic signed [63:0] prod_x_in, prod_y_in, prod_x_ff, prod_y_ff;
   logic signed [31:0] px_d_in, py_d_in, px_d_ff, py_d_ff, px_e_ff, py_e_ff;
   logic signed [34:0] pen_x_in, pen_y_in, pen_x_ff, pen_y_ff;
   logic [1:0]         nx_e_in, ny_e_in, nx_e_ff, ny_e_ff;

   logic               hit_f_ff;
   logic signed [31:0] entry_f_ff, px_f_ff, py_f_ff;
   logic [1:0]         nx_f_ff, ny_f_ff;

   // The pipeline never stalls, so an item can be taken in every cycle.
   assign busy   = 1'b0;
   assign vld_in = start & ~busy;

   // Valid bits travel alongside the data through every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= vld_in;
         for (int k = 1; k < LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Capture the incoming item.
   always_ff @(posedge clock) begin
      in_ff.origin_x     <= req_origin_x;
      in_ff.origin_y     <= req_origin_y;
      in_ff.move_x       <= req_move_x;
      in_ff.move_y       <= req_move_y;
      in_ff.box_min_x    <= req_box_min_x;
      in_ff.box_min_y    <= req_box_min_y;
      in_ff.box_max_x    <= req_box_max_x;
      in_ff.box_max_y    <= req_box_max_y;
      in_ff.box_centre_x <= req_box_centre_x;
      in_ff.box_centre_y <= req_box_centre_y;
   end

   // Form slab differences, their magnitudes and the quotient signs.
   always_comb begin
      logic [32:0] d_min_x, d_max_x, d_min_y, d_max_y;
      logic [32:0] mx, my;
      d_min_x = {in_ff.box_min_x[31], in_ff.box_min_x} - {in_ff.origin_x[31], in_ff.origin_x};
      d_max_x = {in_ff.box_max_x[31], in_ff.box_max_x} - {in_ff.origin_x[31], in_ff.origin_x};
      d_min_y = {in_ff.box_min_y[31], in_ff.box_min_y} - {in_ff.origin_y[31], in_ff.origin_y};
      d_max_y = {in_ff.box_max_y[31], in_ff.box_max_y} - {in_ff.origin_y[31], in_ff.origin_y};
      mx      = {in_ff.move_x[31], in_ff.move_x};
      my      = {in_ff.move_y[31], in_ff.move_y};

      dvd_in[0] = {rbsi_pkg::mag33(d_min_x), 16'h0000};
      dvd_in[1] = {rbsi_pkg::mag33(d_max_x), 16'h0000};
      dvd_in[2] = {rbsi_pkg::mag33(d_min_y), 16'h0000};
      dvd_in[3] = {rbsi_pkg::mag33(d_max_y), 16'h0000};
      neg_in[0] = d_min_x[32] ^ in_ff.move_x[31];
      neg_in[1] = d_max_x[32] ^ in_ff.move_x[31];
      neg_in[2] = d_min_y[32] ^ in_ff.move_y[31];
      neg_in[3] = d_max_y[32] ^ in_ff.move_y[31];
      dvs_x_in  = rbsi_pkg::mag33(mx);
      dvs_y_in  = rbsi_pkg::mag33(my);

      side_r1_in.move_nz_x = (in_ff.move_x != 32'sd0);
      side_r1_in.move_nz_y = (in_ff.move_y != 32'sd0);
      side_r1_in.axis_ok   =
         (side_r1_in.move_nz_x ||
          (in_ff.origin_x > in_ff.box_min_x && in_ff.origin_x < in_ff.box_max_x)) &&
         (side_r1_in.move_nz_y ||
          (in_ff.origin_y > in_ff.box_min_y && in_ff.origin_y < in_ff.box_max_y));
      side_r1_in.origin_x  = in_ff.origin_x;
      side_r1_in.origin_y  = in_ff.origin_y;
      side_r1_in.move_x    = in_ff.move_x;
      side_r1_in.move_y    = in_ff.move_y;
      side_r1_in.span_x    = $signed({in_ff.box_max_x[31], in_ff.box_max_x}
                                     - {in_ff.box_min_x[31], in_ff.box_min_x});
      side_r1_in.span_y    = $signed({in_ff.box_max_y[31], in_ff.box_max_y}
                                     - {in_ff.box_min_y[31], in_ff.box_min_y});
      side_r1_in.centre_x  = in_ff.box_centre_x;
      side_r1_in.centre_y  = in_ff.box_centre_y;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         dvd_ff[k] <= dvd_in[k];
         neg_ff[k] <= neg_in[k];
      end
      dvs_x_ff   <= dvs_x_in;
      dvs_y_ff   <= dvs_y_in;
      side_r1_ff <= side_r1_in;
   end

   // Four slab time dividers: x min, x max, y min, y max.
   rbsi_div u_div_min_x (.clock(clock), .dividend(dvd_ff[0]), .divisor(dvs_x_ff),
                         .negate(neg_ff[0]), .quotient(quot[0]));
   rbsi_div u_div_max_x (.clock(clock), .dividend(dvd_ff[1]), .divisor(dvs_x_ff),
                         .negate(neg_ff[1]), .quotient(quot[1]));
   rbsi_div u_div_min_y (.clock(clock), .dividend(dvd_ff[2]), .divisor(dvs_y_ff),
                         .negate(neg_ff[2]), .quotient(quot[2]));
   rbsi_div u_div_max_y (.clock(clock), .dividend(dvd_ff[3]), .divisor(dvs_y_ff),
                         .negate(neg_ff[3]), .quotient(quot[3]));

   // Side data waits as long as the dividers take.
   always_ff @(posedge clock) begin
      side_dl_ff[0] <= side_r1_ff;
      for (int k = 1; k < DL; k++) begin
         side_dl_ff[k] <= side_dl_ff[k-1];
      end
   end

   // Combine the slabs into entry and exit times and decide the hit.
   always_comb begin
      logic signed [31:0] lo_x, hi_x, lo_y, hi_y, ex;
      rbsi_pkg::side_type s;
      s    = side_dl_ff[DL-1];
      lo_x = (quot[0] < quot[1]) ? quot[0] : quot[1];
      hi_x = (quot[0] < quot[1]) ? quot[1] : quot[0];
      lo_y = (quot[2] < quot[3]) ? quot[2] : quot[3];
      hi_y = (quot[2] < quot[3]) ? quot[3] : quot[2];
      entry_b_in = rbsi_pkg::S32_MIN;
      ex         = rbsi_pkg::S32_MAX;
      if (s.move_nz_x) begin
         entry_b_in = lo_x;
         ex         = hi_x;
      end
      if (s.move_nz_y) begin
         if (lo_y > entry_b_in) begin
            entry_b_in = lo_y;
         end
         if (hi_y < ex) begin
            ex = hi_y;
         end
      end
      hit_b_in = s.axis_ok && (ex > entry_b_in) && (ex > 32'sd0) &&
                 (entry_b_in < rbsi_pkg::FX_ONE);
   end

   always_ff @(posedge clock) begin
      entry_b_ff <= entry_b_in;
      hit_b_ff   <= hit_b_in;
      side_b_ff  <= side_dl_ff[DL-1];
   end

   // Scale the move vector by the entry time.
   assign prod_x_in = side_b_ff.move_x * entry_b_ff;
   assign prod_y_in = side_b_ff.move_y * entry_b_ff;

   always_ff @(posedge clock) begin
      prod_x_ff  <= prod_x_in;
      prod_y_ff  <= prod_y_in;
      entry_c_ff <= entry_b_ff;
      hit_c_ff   <= hit_b_ff;
      side_c_ff  <= side_b_ff;
   end

   // Drop the fraction toward zero, add the origin and clamp.
   always_comb begin
      logic signed [63:0] adj_x, adj_y;
      logic signed [47:0] scl_x, scl_y;
      adj_x   = prod_x_ff + (prod_x_ff[63] ? 64'sd65535 : 64'sd0);
      adj_y   = prod_y_ff + (prod_y_ff[63] ? 64'sd65535 : 64'sd0);
      scl_x   = adj_x[63:16];
      scl_y   = adj_y[63:16];
      px_d_in = rbsi_pkg::sat49($signed({scl_x[47], scl_x})
                + $signed({{17{side_c_ff.origin_x[31]}}, side_c_ff.origin_x}));
      py_d_in = rbsi_pkg::sat49($signed({scl_y[47], scl_y})
                + $signed({{17{side_c_ff.origin_y[31]}}, side_c_ff.origin_y}));
   end

   always_ff @(posedge clock) begin
      px_d_ff    <= px_d_in;
      py_d_ff    <= py_d_in;
      entry_d_ff <= entry_c_ff;
      hit_d_ff   <= hit_c_ff;
      side_d_ff  <= side_c_ff;
   end

   // Offsets from the centre give the doubled penetration on each axis.
   always_comb begin
      logic [32:0] dx, dy;
      dx = {px_d_ff[31], px_d_ff} - {side_d_ff.centre_x[31], side_d_ff.centre_x};
      dy = {py_d_ff[31], py_d_ff} - {side_d_ff.centre_y[31], side_d_ff.centre_y};
      pen_x_in = $signed({{2{side_d_ff.span_x[32]}}, side_d_ff.span_x})
                 - $signed({2'b00, rbsi_pkg::mag33(dx), 1'b0});
      pen_y_in = $signed({{2{side_d_ff.span_y[32]}}, side_d_ff.span_y})
                 - $signed({2'b00, rbsi_pkg::mag33(dy), 1'b0});
      nx_e_in  = dx[32] ? rbsi_pkg::NORM_NEG :
                 ((dx != 33'd0) ? rbsi_pkg::NORM_POS : rbsi_pkg::NORM_ZERO);
      ny_e_in  = dy[32] ? rbsi_pkg::NORM_NEG :
                 ((dy != 33'd0) ? rbsi_pkg::NORM_POS : rbsi_pkg::NORM_ZERO);
   end

   always_ff @(posedge clock) begin
      pen_x_ff   <= pen_x_in;
      pen_y_ff   <= pen_y_in;
      nx_e_ff    <= nx_e_in;
      ny_e_ff    <= ny_e_in;
      px_e_ff    <= px_d_ff;
      py_e_ff    <= py_d_ff;
      entry_e_ff <= entry_d_ff;
      hit_e_ff   <= hit_d_ff;
   end

   // Pick the face and zero every field of a miss.
   always_ff @(posedge clock) begin
      hit_f_ff   <= hit_e_ff;
      entry_f_ff <= hit_e_ff ? entry_e_ff : 32'sd0;
      px_f_ff    <= hit_e_ff ? px_e_ff : 32'sd0;
      py_f_ff    <= hit_e_ff ? py_e_ff : 32'sd0;
      nx_f_ff    <= (hit_e_ff && (pen_x_ff < pen_y_ff)) ? nx_e_ff : rbsi_pkg::NORM_ZERO;
      ny_f_ff    <= (hit_e_ff && !(pen_x_ff < pen_y_ff)) ? ny_e_ff : rbsi_pkg::NORM_ZERO;
   end

   assign rsp_valid      = vld_ff[LAT-1];
   assign rsp_hit        = hit_f_ff;
   assign rsp_entry_time = entry_f_ff;
   assign rsp_point_x    = px_f_ff;
   assign rsp_point_y    = py_f_ff;
   assign rsp_normal_x   = $signed(nx_f_ff);
   assign rsp_normal_y   = $signed(ny_f_ff);

   // A result only ever follows an item taken the full latency earlier.
   `RBSI_ASSERT_IMPLY(a_result_has_item, clock, reset, rsp_valid,
      $past(start && !busy, LAT))
   // A miss carries all-zero fields.
   `RBSI_ASSERT_IMPLY(a_miss_is_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_entry_time == 32'sd0 && rsp_point_x == 32'sd0 && rsp_point_y == 32'sd0 &&
      rsp_normal_x == 2'sd0 && rsp_normal_y == 2'sd0)
   // Only one face is ever chosen, and a hit lies before the segment end.
   `RBSI_ASSERT_IMPLY(a_one_face, clock, reset, rsp_valid && rsp_hit,
      (rsp_normal_x == 2'sd0 || rsp_normal_y == 2'sd0) &&
      rsp_entry_time < rbsi_pkg::FX_ONE)
   // The hit decision passes from the penetration stage straight to the output register.
   `RBSI_ASSERT_NEXT(a_hit_follows, clock, reset, vld_ff[LAT-2] && !hit_e_ff, !rsp_hit)

endmodule

// ----- tb/ray_box_slab_intersect_unit_checker.sv -----
// ----------------------------------------------------------------------------
// Ray box slab intersect unit: result checker
// Watches accepted items, predicts each result of the slab test and compares
// every strobed result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ray_box_slab_intersect_unit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_move_x,
   input  logic signed [31:0] req_move_y,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   input  logic signed [31:0] req_box_centre_x,
   input  logic signed [31:0] req_box_centre_y,
   input  logic               rsp_valid,
   input  logic               rsp_hit,
   input  logic signed [31:0] rsp_entry_time,
   input  logic signed [31:0] rsp_point_x,
   input  logic signed [31:0] rsp_point_y,
   input  logic signed [1:0]  rsp_normal_x,
   input  logic signed [1:0]  rsp_normal_y,
   output int                 fail_count,
   output int                 pending_count,
   output int                 hit_count,
   output int                 result_count
);

   typedef struct packed {
      logic               hit;
      logic signed [31:0] entry_time;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [1:0]  normal_x;
      logic signed [1:0]  normal_y;
   } intersect_type;

   intersect_type intersect_queue[$];

   // Saturate a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
      if (v > 96'sd2147483647) return 32'sh7fff_ffff;
      if (v < -96'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Predict the slab test for one item.
   function automatic intersect_type slab_predict(
      input logic signed [31:0] ox, oy, mx, my, lx, ly, hx, hy, cx, cy);
      logic signed [95:0] org[2], mv[2], lo_b[2], hi_b[2], cen[2];
      logic signed [95:0] entry, leave, t1, t2, tl, th, px, py, dx, dy, penx, peny;
      intersect_type r;
      logic ok;
      org[0] = ox; org[1] = oy; mv[0] = mx; mv[1] = my;
      lo_b[0] = lx; lo_b[1] = ly; hi_b[0] = hx; hi_b[1] = hy;
      cen[0] = cx; cen[1] = cy;
      entry = -96'sd2147483648;
      leave = 96'sd2147483647;
      ok = 1'b1;
      r = '0;
      for (int i = 0; i < 2; i++) begin
         if (!ok) break;
         if (mv[i] != 0) begin
            t1 = clamp32(((lo_b[i] - org[i]) * 96'sd65536) / mv[i]);
            t2 = clamp32(((hi_b[i] - org[i]) * 96'sd65536) / mv[i]);
            tl = (t1 < t2) ? t1 : t2;
            th = (t1 < t2) ? t2 : t1;
            if (tl > entry) entry = tl;
            if (th < leave) leave = th;
         end else if (org[i] <= lo_b[i] || org[i] >= hi_b[i]) begin
            ok = 1'b0;
         end
      end
      if (ok && !(leave > entry && leave > 0 && entry < 96'sd65536)) ok = 1'b0;
      if (ok) begin
         px = clamp32(org[0] + (mv[0] * entry) / 96'sd65536);
         py = clamp32(org[1] + (mv[1] * entry) / 96'sd65536);
         dx = px - cen[0];
         dy = py - cen[1];
         penx = (hi_b[0] - lo_b[0]) - 2 * ((dx < 0) ? -dx : dx);
         peny = (hi_b[1] - lo_b[1]) - 2 * ((dy < 0) ? -dy : dy);
         r.hit = 1'b1;
         r.entry_time = entry[31:0];
         r.point_x = px[31:0];
         r.point_y = py[31:0];
         if (penx < peny) r.normal_x = (dx > 0) ? 2'sd1 : (dx < 0) ? -2'sd1 : 2'sd0;
         else r.normal_y = (dy > 0) ? 2'sd1 : (dy < 0) ? -2'sd1 : 2'sd0;
      end
      return r;
   endfunction

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   assign pending_count = intersect_queue.size();

   // Queue predictions for taken items and compare strobed results.
   always @(posedge clock) begin
      intersect_type want;
      if (reset) begin
         fail_count = 0;
         hit_count = 0;
         result_count = 0;
      end else begin
         if (rsp_valid) begin
            result_count++;
            if (intersect_queue.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_hit), 32'd0);
            end else begin
               want = intersect_queue.pop_front();
               if (want.hit) hit_count++;
               if (rsp_hit !== want.hit)
                  report_mismatch("hit", 32'(rsp_hit), 32'(want.hit));
               if (rsp_entry_time !== want.entry_time)
                  report_mismatch("entry_time", rsp_entry_time, want.entry_time);
               if (rsp_point_x !== want.point_x)
                  report_mismatch("point_x", rsp_point_x, want.point_x);
               if (rsp_point_y !== want.point_y)
                  report_mismatch("point_y", rsp_point_y, want.point_y);
               if (rsp_normal_x !== want.normal_x)
                  report_mismatch("normal_x", 32'(rsp_normal_x), 32'(want.normal_x));
               if (rsp_normal_y !== want.normal_y)
                  report_mismatch("normal_y", 32'(rsp_normal_y), 32'(want.normal_y));
            end
         end
         if (start && !busy) begin
            intersect_queue.push_back(slab_predict(req_origin_x, req_origin_y,
               req_move_x, req_move_y, req_box_min_x, req_box_min_y,
               req_box_max_x, req_box_max_y, req_box_centre_x, req_box_centre_y));
         end
      end
   end

endmodule

// ----- tb/ray_box_slab_intersect_unit_test.sv -----
// ----------------------------------------------------------------------------
// Ray box slab intersect unit: testbench top
// Drives directed and random segment/box items with random gaps and hands
// results to the checker; gives the verdict once every result has come or the drain wait ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ray_box_slab_intersect_unit_test;

   localparam int RANDOM_ITEMS = 1600;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 200000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_origin_x, req_origin_y, req_move_x, req_move_y;
   logic signed [31:0] req_box_min_x, req_box_min_y, req_box_max_x, req_box_max_y;
   logic signed [31:0] req_box_centre_x, req_box_centre_y;
   logic               rsp_valid, rsp_hit;
   logic signed [31:0] rsp_entry_time, rsp_point_x, rsp_point_y;
   logic signed [1:0]  rsp_normal_x, rsp_normal_y;
   int                 fail_count, pending_count, hit_count, result_count;
   int                 cycle_count = 0;
   int                 item_count;

   ray_box_slab_intersect_unit dut (.*);

   ray_box_slab_intersect_unit_checker checker_inst (.*);

   // Clock and a watchdog on the cycle count.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // A random Q16.16 value: mostly modest, sometimes anything.
   function automatic logic signed [31:0] rand_fx(input int spread);
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $signed($urandom_range(0, 2 * spread)) - spread;
   endfunction

   // Present one item and hold it until the block takes it.
   task automatic send_item(input logic signed [31:0] ox, oy, mx, my, lx, ly,
                            hx, hy, cx, cy);
      req_origin_x <= ox;  req_origin_y <= oy;
      req_move_x <= mx;    req_move_y <= my;
      req_box_min_x <= lx; req_box_min_y <= ly;
      req_box_max_x <= hx; req_box_max_y <= hy;
      req_box_centre_x <= cx; req_box_centre_y <= cy;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      item_count++;
   endtask

   // Random item, mostly a segment aimed through a well-formed box.
   task automatic send_random(input bit quiet);
      logic signed [31:0] lx, ly, hx, hy, ox, oy;
      int spread;
      spread = ($urandom_range(0, 3) == 0) ? 32'h4000_0000 : 32'h0080_0000;
      lx = rand_fx(spread);
      ly = rand_fx(spread);
      hx = lx + $urandom_range(0, 32'h0040_0000);
      hy = ly + $urandom_range(0, 32'h0040_0000);
      if ($urandom_range(0, 9) == 0) begin
         hx = rand_fx(spread);
         hy = rand_fx(spread);
      end
      ox = rand_fx(spread);
      oy = rand_fx(spread);
      case ($urandom_range(0, 9))
         0: send_item(ox, oy, 0, rand_fx(spread), lx, ly, hx, hy, lx, ly);
         1: send_item(ox, oy, rand_fx(spread), 0, lx, ly, hx, hy, hx, hy);
         2: send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
         default: send_item(ox, oy, (lx >>> 1) + (hx >>> 1) - ox + rand_fx(32'h1_0000),
                            (ly >>> 1) + (hy >>> 1) - oy + rand_fx(32'h1_0000),
                            lx, ly, hx, hy, (lx >>> 1) + (hx >>> 1) + rand_fx(8),
                            (ly >>> 1) + (hy >>> 1) + rand_fx(8));
      endcase
      if (!quiet && $urandom_range(0, 24) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Stimulus: directed corners, random items, pause to drain, then verdict.
   initial begin
      logic signed [31:0] mn, mx;
      int drain;
      mn = 32'sh8000_0000;
      mx = 32'sh7fff_ffff;
      item_count = 0;
      reset = 1'b1;
      start = 1'b0;
      {req_origin_x, req_origin_y, req_move_x, req_move_y} = '0;
      {req_box_min_x, req_box_min_y, req_box_max_x, req_box_max_y} = '0;
      {req_box_centre_x, req_box_centre_y} = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Plain hit through a 2x1 box, and the same segment missing it.
      send_item(-32'sh2_0000, 32'sh8000, 32'sh4_0000, 0, -32'sh1_0000, 0,
                32'sh1_0000, 32'sh1_0000, 0, 32'sh8000);
      send_item(-32'sh2_0000, 32'sh2_0000, 32'sh4_0000, 0, -32'sh1_0000, 0,
                32'sh1_0000, 32'sh1_0000, 0, 32'sh8000);
      // No axis moves, origin inside: entry at the most negative time.
      send_item(32'sh8000, 32'sh8000, 0, 0, 0, 0, 32'sh1_0000, 32'sh1_0000,
                32'sh8000, 32'sh8000);
      // No axis moves, origin on a face.
      send_item(0, 32'sh8000, 0, 0, 0, 0, 32'sh1_0000, 32'sh1_0000, 0, 0);
      // Diagonal tie, which goes to y.
      send_item(-32'sh2_0000, -32'sh2_0000, 32'sh4_0000, 32'sh4_0000,
                -32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 0, 0);
      // Negative movement, and the segment ending short of the box.
      send_item(32'sh3_0000, 32'sh8000, -32'sh4_0000, 32'sh10, 0, 0,
                32'sh1_0000, 32'sh1_0000, 32'sh8000, 32'sh8000);
      send_item(-32'sh3_0000, 32'sh8000, 32'sh1_0000, 0, 0, 0,
                32'sh1_0000, 32'sh1_0000, 32'sh8000, 32'sh8000);
      // Segment starting inside the box.
      send_item(32'sh8000, 32'sh8000, 32'sh1_0000, 32'sh4000, 0, 0,
                32'sh1_0000, 32'sh1_0000, 0, 0);
      // Extremes: saturating slab times and hit point, tiny moves.
      send_item(mn, mn, 1, 1, mn, mn, mx, mx, mx, mn);
      send_item(mx, mn, -1, 1, mn, mn, mx, mx, 0, 0);
      send_item(mn, mx, mx, mn, mn, mn, mx, mx, mn, mx);
      send_item(mx, mx, mn, mn, mn, mn, mx, mx, mx, mx);
      send_item(0, 0, mn, mx, mn, mn, mx, mx, 0, 0);
      send_item(-1, -1, 1, 1, 0, 0, 1, 1, 0, 0);
      // Inverted box, and a zero-width one.
      send_item(-32'sh2_0000, 32'sh8000, 32'sh4_0000, 0, 32'sh1_0000, 0,
                -32'sh1_0000, 32'sh1_0000, 0, 0);
      send_item(-32'sh2_0000, -32'sh2_0000, 32'sh4_0000, 32'sh4_0000, 0, 0,
                0, 0, 0, 0);
      send_item(32'shffff_ffff, 32'shaaaa_5555, 32'h5555_aaaa, 32'shffff_ffff,
                32'sh0000_0000, 32'shffff_ffff, 32'shffff_ffff, 32'sh0, mn, mx);

      // Random part, with a stretch free of gaps in the middle.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send_random(n >= 600 && n < 900);
         if (n == 1000) begin
            // Hold off until every outstanding result has come back.
            start <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
      end
      start <= 1'b0;

      drain = 0;
      while (pending_count != 0 && drain < 10000) begin
         @(posedge clock);
         drain++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d segment/box items; %0d results checked, %0d of them hits.",
               item_count, result_count, hit_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, pending_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
